// ===== design/visual_crypto_block_decode_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the visual crypto block decoder
// Macros that compile to concurrent assertions in simulation and to nothing
// in synthesis. They expect clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef VISUAL_CRYPTO_BLOCK_DECODE_DEFINES_SVH
`define VISUAL_CRYPTO_BLOCK_DECODE_DEFINES_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define VCBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define VCBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VCBD_ASSERT(lbl, prop, msg)
`define VCBD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/vcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// vcbd_pkg
// Shared constants and types of the visual crypto block decoder.
// ----------------------------------------------------------------------------
package vcbd_pkg;

  localparam int ROW_BYTES_MAX = 256;
  localparam int COL_W         = $clog2(ROW_BYTES_MAX);
  localparam int WIDTH_W       = 12;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd64;
  localparam logic [WIDTH_W-1:0] WIDTH_MIN   = 12'd2;

  // control that travels with an item from the front stage to the pixel stage
  typedef struct packed {
    logic       odd;
    logic [2:0] pairs;
    logic       row_hit;
    logic       wrap;
  } s1_ctl_t;

endpackage

// ===== design/vcbd_line_buf.sv =====
// ----------------------------------------------------------------------------
// vcbd_line_buf
// Single-port line buffer holding one even raster row, registered read.
// ----------------------------------------------------------------------------
module vcbd_line_buf
  import vcbd_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [COL_W-1:0] addr,
  input  logic [7:0]       wdata,
  output logic [7:0]       rdata
);

  logic [7:0] mem [ROW_BYTES_MAX];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/visual_crypto_block_decode.sv =====
// Path: a raster byte is registered in the pixel stage, its result in the output register.
// Throughput: one raster byte per cycle when not stalled; each byte takes one access of the
//   single-port line buffer (write on even rows, read on odd rows).
// Output stalls hold the pixel stage only while it holds a result; other bytes keep flowing.
// Reset: width 64, frame restarted, pipeline empty; line buffer contents undefined.
// ----------------------------------------------------------------------------
// visual_crypto_block_decode
// Joins 2x2 subpixel blocks of a stacked share raster into packed output bytes.
// ----------------------------------------------------------------------------
`include "visual_crypto_block_decode_defines.svh"

module visual_crypto_block_decode
  import vcbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [WIDTH_W-1:0] cfg_input_width,
  // raster input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_raster_byte,
  // decoded output
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_row_end
);

  localparam logic [11:0] PIX_MAX = 12'(ROW_BYTES_MAX * 8);
  localparam logic [8:0]  RB_MAX  = 9'(ROW_BYTES_MAX);

  // ---------------- front stage state ----------------
  logic [WIDTH_W-1:0] width_r;
  logic               odd_row_r;
  logic [COL_W-1:0]   byte_column_r;
  logic [9:0]         pix_count_r;

  // ---------------- pixel stage ----------------
  logic               s1_valid_r;
  s1_ctl_t            s1_ctl_r;
  logic [7:0]         s1_byte_r;
  logic [7:0]         acc_r;
  logic [2:0]         acc_bits_r;

  // ---------------- output register ----------------
  logic               out_valid_r;
  logic [7:0]         out_byte_r;
  logic               out_row_end_r;

  // derived row geometry
  logic [11:0] w_eff;
  logic [12:0] rb_sum;
  logic [9:0]  rb_raw;
  logic [8:0]  row_bytes;
  logic [11:0] pix_full;
  logic [11:0] pix_w;
  logic [10:0] row_pixels;

  always_comb begin
    w_eff      = (width_r < WIDTH_MIN) ? WIDTH_MIN : width_r;
    rb_sum     = {1'b0, w_eff} + 13'd7;
    rb_raw     = rb_sum[12:3];
    row_bytes  = (rb_raw > {1'b0, RB_MAX}) ? RB_MAX : rb_raw[8:0];
    pix_full   = {w_eff[11:1], 1'b0};
    pix_w      = (pix_full > PIX_MAX) ? PIX_MAX : pix_full;
    row_pixels = pix_w[11:1];
  end

  // front stage: pixel pairs of this byte, row bookkeeping
  logic        in_acc;
  logic [11:0] col_pix;
  logic [11:0] rem_full;
  logic [3:0]  rem;
  logic [2:0]  pairs;
  logic [10:0] cnt_sum;
  logic        row_hit;
  logic [8:0]  col_inc;
  logic        wrap;
  s1_ctl_t     s0_ctl;

  always_comb begin
    col_pix  = {1'b0, byte_column_r, 3'b000};
    rem_full = (pix_w > col_pix) ? (pix_w - col_pix) : 12'd0;
    rem      = (rem_full > 12'd8) ? 4'd8 : rem_full[3:0];
    pairs    = odd_row_r ? rem[3:1] : 3'd0;
    cnt_sum  = {1'b0, pix_count_r} + {8'd0, pairs};
    row_hit  = (pairs != 3'd0) && (cnt_sum >= row_pixels);
    col_inc  = {1'b0, byte_column_r} + 9'd1;
    wrap     = (col_inc >= row_bytes);
    s0_ctl   = '{odd: odd_row_r, pairs: pairs, row_hit: row_hit, wrap: wrap};
  end

  // pixel stage: AND of the stored and current rows, pairwise reduction
  logic [7:0] rd_data;
  logic [7:0] m;
  logic [3:0] px;
  logic [3:0] take;
  logic [7:0] acc_new;
  logic [3:0] bits_new;
  logic [7:0] obyte;
  logic       s1_emit;
  logic       adv1;

  always_comb begin
    m        = rd_data & s1_byte_r;
    px       = {m[7] & m[6], m[5] & m[4], m[3] & m[2], m[1] & m[0]};
    take     = px >> (3'd4 - s1_ctl_r.pairs);
    acc_new  = (acc_r << s1_ctl_r.pairs) | {4'd0, take};
    bits_new = {1'b0, acc_bits_r} + {1'b0, s1_ctl_r.pairs};
    obyte    = acc_new << (4'd8 - bits_new);
    s1_emit  = s1_ctl_r.row_hit || ((s1_ctl_r.pairs != 3'd0) && (bits_new == 4'd8));
    adv1     = s1_valid_r && (!s1_emit || !out_valid_r || out_ready);
  end

  assign in_ready  = !s1_valid_r || adv1;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  vcbd_line_buf u_line_buf (
    .clk   (clk),
    .we    (in_acc && !odd_row_r),
    .re    (in_acc && odd_row_r),
    .addr  (byte_column_r),
    .wdata (in_raster_byte),
    .rdata (rd_data)
  );

  // front stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r       <= WIDTH_RESET;
      odd_row_r     <= 1'b0;
      byte_column_r <= '0;
      pix_count_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      width_r       <= cfg_input_width;
      odd_row_r     <= 1'b0;
      byte_column_r <= '0;
      pix_count_r   <= '0;
    end else if (in_acc) begin
      if (wrap) begin
        odd_row_r     <= !odd_row_r;
        byte_column_r <= '0;
        pix_count_r   <= '0;
      end else begin
        byte_column_r <= col_inc[COL_W-1:0];
        pix_count_r   <= row_hit ? 10'd0 : cnt_sum[9:0];
      end
    end
  end

  // pixel stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      acc_r      <= '0;
      acc_bits_r <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv1) begin
        s1_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        acc_r      <= '0;
        acc_bits_r <= '0;
      end else if (adv1) begin
        if (s1_emit || s1_ctl_r.wrap) begin
          acc_r      <= '0;
          acc_bits_r <= '0;
        end else begin
          acc_r      <= acc_new;
          acc_bits_r <= bits_new[2:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctl_r  <= s0_ctl;
      s1_byte_r <= in_raster_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv1 && s1_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && s1_emit) begin
      out_byte_r    <= obyte;
      out_row_end_r <= s1_ctl_r.row_hit;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_row_end = out_row_end_r;

  // a stalled pixel stage keeps its item and its line buffer data
  `VCBD_ASSERT(a_s1_hold, s1_valid_r && !adv1 |=> s1_valid_r && $stable(s1_byte_r) && $stable(rd_data), "pixel stage lost its item while stalled")
  // even rows only fill the line buffer
  `VCBD_ASSERT(a_even_quiet, s1_valid_r && !s1_ctl_r.odd |-> !s1_emit, "result from an even row")
  // the input side blocks only behind a waiting result
  `VCBD_ASSERT(a_ready_cause, !in_ready |-> s1_valid_r && out_valid_r && !out_ready, "input blocked without a waiting result")
  // column pointer stays inside the row
  `VCBD_ASSERT(a_col_range, {1'b0, byte_column_r} < row_bytes, "byte column beyond row")
  `VCBD_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !s1_valid_r && !out_valid_r, "pipeline not empty after reset")

endmodule

// ===== verif/tb_visual_crypto_block_decode.sv =====
// ----------------------------------------------------------------------------
// tb_visual_crypto_block_decode
// Streams packed share rasters through the 2x2 block decoder at a range of
// image widths. A cycle-free model of the line buffer and pixel packer
// predicts every output byte and row end. The monitor checks outputs in order
// while both channels stall at random during the first 480 raster bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_visual_crypto_block_decode;
  import vcbd_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int ITEM_TARGET  = 700;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       row_end;
  } dec_byte_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [WIDTH_W-1:0] cfg_input_width = WIDTH_RESET;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_raster_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_byte;
  logic               out_row_end;

  // stimulus and expected output
  logic [7:0] raster_q[$];
  dec_byte_t  decoded_q[$];
  int         queued_total = 0;
  int         raster_taken = 0;
  int         errors = 0;
  int         quiet_cycles = 0;
  int         send_gap_pct;
  int         recv_gap_pct;

  // decoder model state
  logic [7:0]         line_mem [ROW_BYTES_MAX];
  logic [WIDTH_W-1:0] width_reg;
  logic               odd_row;
  int                 byte_col;
  logic [7:0]         pix_acc;
  int                 acc_cnt;
  int                 pix_cnt;

  visual_crypto_block_decode uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_input_width (cfg_input_width),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_raster_byte  (in_raster_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_row_end     (out_row_end)
  );

  always #10 clk = ~clk;

  // stall profile follows progress through the run
  always_comb begin
    if (raster_taken < 240) begin
      send_gap_pct = 38;
      recv_gap_pct = 62;
    end else if (raster_taken < 480) begin
      send_gap_pct = 62;
      recv_gap_pct = 38;
    end else begin
      send_gap_pct = 0;
      recv_gap_pct = 0;
    end
  end

  task automatic restart_frame();
    odd_row = 1'b0;
    byte_col = 0;
    pix_acc = 8'h00;
    acc_cnt = 0;
    pix_cnt = 0;
  endtask

  // one raster byte through the decoder; queues the output byte it completes
  task automatic decode_raster(input logic [7:0] b);
    int         w;
    int         rb;
    int         pix_w;
    int         row_pix;
    int         col;
    int         left;
    int         pairs;
    int         p;
    logic [7:0] m;
    logic       emit;
    dec_byte_t  res;
    w = (width_reg < WIDTH_MIN) ? 2 : int'(width_reg);
    rb = (w + 7) / 8;
    if (rb > ROW_BYTES_MAX) rb = ROW_BYTES_MAX;
    pix_w = w & ~1;
    if (pix_w > rb * 8) pix_w = rb * 8;
    row_pix = pix_w / 2;
    col = (byte_col >= rb) ? 0 : byte_col;
    emit = 1'b0;
    res = '0;
    if (!odd_row) begin
      line_mem[col] = b;
    end else begin
      m = line_mem[col] & b;
      left = (col * 8 < pix_w) ? pix_w - col * 8 : 0;
      if (left > 8) left = 8;
      pairs = left / 2;
      for (p = 0; p < pairs; p++) begin
        // black only when both subpixels of the pair are black in both rows
        pix_acc = {pix_acc[6:0], &m[7-2*p -: 2]};
        acc_cnt++;
        pix_cnt++;
        if (pix_cnt >= row_pix) begin
          res.data = pix_acc << (8 - acc_cnt);
          res.row_end = 1'b1;
          emit = 1'b1;
          pix_acc = 8'h00;
          acc_cnt = 0;
          pix_cnt = 0;
        end else if (acc_cnt == 8) begin
          res.data = pix_acc;
          res.row_end = 1'b0;
          emit = 1'b1;
          pix_acc = 8'h00;
          acc_cnt = 0;
        end
      end
    end
    col++;
    if (col >= rb) begin
      col = 0;
      odd_row = ~odd_row;
      pix_acc = 8'h00;
      acc_cnt = 0;
      pix_cnt = 0;
    end
    byte_col = col;
    if (emit) decoded_q.push_back(res);
  endtask

  // raster driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_raster(in_raster_byte);
        raster_taken <= raster_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (raster_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_raster_byte <= raster_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    dec_byte_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected item out_byte=%02h row_end=%0b",
                   $time, out_byte, out_row_end);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.data) begin
            $display("%0t: out_byte expected %02h actual %02h",
                     $time, want.data, out_byte);
            errors++;
          end
          if (out_row_end !== want.row_end) begin
            $display("%0t: out_row_end expected %0b actual %0b",
                     $time, want.row_end, out_row_end);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[visual_crypto_block_decode] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (raster_q.size() != 0 || in_valid || decoded_q.size() != 0);
    // an item with no output may still be in the pipe
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // new width, then row_pairs full row pairs, optionally a ragged tail
  task automatic run_phase(input logic [WIDTH_W-1:0] w, input int row_pairs,
                           input bit ragged);
    int rb;
    int n;
    cfg_input_width <= w;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    width_reg = w;
    restart_frame();
    rb = (w < WIDTH_MIN) ? 1 : (int'(w) + 7) / 8;
    if (rb > ROW_BYTES_MAX) rb = ROW_BYTES_MAX;
    n = 2 * rb * row_pairs;
    // tail ends inside an even row (no partner) or inside an odd row
    if (ragged) n += $urandom_range(1, 2 * rb - 1 > 1 ? 2 * rb - 1 : 1);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0:       raster_q.push_back(8'hFF);
        1:       raster_q.push_back(8'h00);
        2, 3:    raster_q.push_back(8'($urandom));
        default: raster_q.push_back(8'($urandom | $urandom));
      endcase
    end
    queued_total += n;
    wait_drained();
  endtask

  initial begin
    logic [WIDTH_W-1:0] w;
    int                 rb;
    width_reg = WIDTH_RESET;
    restart_frame();
    for (int i = 0; i < ROW_BYTES_MAX; i++) line_mem[i] = 8'h00;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset width of 64: one row pair of hand-picked bytes
    raster_q = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'hCC, 8'h33, 8'hF0, 8'h0F,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hCC, 8'h33, 8'hFF, 8'h0F};
    queued_total = 16;
    wait_drained();

    // widths below two, odd widths, byte-aligned widths
    run_phase(12'd0, 1, 1'b1);
    run_phase(12'd1, 2, 1'b1);
    run_phase(12'd3, 1, 1'b1);
    run_phase(12'd2, 1, 1'b0);
    run_phase(12'd8, 1, 1'b1);
    run_phase(12'd15, 1, 1'b1);
    run_phase(12'd16, 2, 1'b0);
    run_phase(12'd17, 1, 1'b1);
    // saturated width: full 256-byte rows
    run_phase(12'hFFF, 1, 1'b0);

    while (queued_total < ITEM_TARGET) begin
      if ($urandom_range(3) == 0) w = 12'($urandom_range(73, 300));
      else w = 12'($urandom_range(0, 72));
      rb = (int'(w) + 7) / 8;
      run_phase(w, (rb > 16) ? 1 : $urandom_range(1, 3), $urandom_range(2) == 0);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && decoded_q.size() == 0) begin
      $display("[visual_crypto_block_decode] OK");
    end else begin
      $display("[visual_crypto_block_decode] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/vcbd_pkg.sv
design/vcbd_line_buf.sv
design/visual_crypto_block_decode.sv
verif/tb_visual_crypto_block_decode.sv
